FILE: hdl/greedy_vertex_cover_defines.svh
// Assertion macros shared by the RTL.
`ifndef GREEDY_VERTEX_COVER_DEFINES_SVH
`define GREEDY_VERTEX_COVER_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define GVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define GVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define GVC_ASSERT(lbl, clk, rst_n, prop, msg)
`define GVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/gvc_pkg.sv
`timescale 1ns / 1ps

package gvc_pkg;

    localparam int MAX_VERTICES    = 1024;
    localparam int HALF_EDGE_SLOTS = 32768;

    localparam int VW  = $clog2(MAX_VERTICES);     // vertex address
    localparam int SW  = $clog2(HALF_EDGE_SLOTS);  // half-edge slot address
    localparam int CW  = SW + 1;                   // half-edge count, degree
    localparam int NW  = 11;                       // vertex_count / cover_size field
    localparam int EW  = 10;                       // endpoint field
    localparam int CTW = (VW + 1 > NW) ? VW + 1 : NW;  // vertex counter
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_PAIR_MODE    = 2'd1;

    localparam logic [1:0] KIND_CLEAR   = 2'd0;
    localparam logic [1:0] KIND_ADD     = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] slot;
    } t_head;

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] next;
        logic [VW-1:0] far;
    } t_link;

    typedef struct packed {
        logic          marked;
        logic [CW-1:0] deg;
    } t_deg;

    typedef enum logic [4:0] {
        S_RST_CLR, S_IDLE, S_CLR,
        S_ADD_RD_A, S_ADD_WR_A, S_ADD_RD_B, S_ADD_WR_B,
        S_DG_RD, S_DG_HQ, S_DG_WALK, S_DG_LK,
        S_SC_INIT, S_SC_RD, S_SC_CMP, S_SC_END,
        S_TK_HD, S_TK_HQ, S_TK_WALK, S_TK_LK, S_TK_DEC, S_TK_DONE,
        S_PR_RD, S_PR_CHK, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_WIPE_ALL, OP_WIPE_HEAD,
        OP_ADD_RD_A, OP_ADD_WR_A, OP_ADD_RD_B, OP_ADD_WR_B,
        OP_DG_RD, OP_DG_HQ, OP_DG_WALK, OP_DG_LK,
        OP_SC_INIT, OP_SC_RD, OP_SC_CMP, OP_SC_END,
        OP_TK_HD, OP_TK_HQ, OP_TK_LK, OP_TK_DEC,
        OP_PR_RD, OP_PR_CHK
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic add_bad;
        logic idx_end;
        logic sweep_last;
        logic ok;
        logic best_zero;
        logic h_marked;
        logic second;
        logic pair;
    } t_sts;

endpackage

FILE: hdl/gvc_datapath.sv
`timescale 1ns / 1ps

module gvc_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gvc_pkg::t_cmd              i_cmd,
    input  logic [gvc_pkg::EW-1:0]     i_end_a,
    input  logic [gvc_pkg::EW-1:0]     i_end_b,
    input  logic                       i_cfg_valid,
    input  logic [gvc_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [gvc_pkg::NW-1:0]     i_cfg_data,
    output gvc_pkg::t_sts              o_sts,
    output logic [gvc_pkg::NW-1:0]     o_cover_size,
    output logic                       o_edges_dropped
);
    import gvc_pkg::*;

    // storage
    t_head r_head_mem [MAX_VERTICES];
    t_link r_link_mem [HALF_EDGE_SLOTS];
    t_deg  r_deg_mem  [MAX_VERTICES];
    t_head r_head_q;
    t_link r_link_q;
    t_deg  r_deg_q;

    logic [NW-1:0]  r_vcnt;
    logic           r_pair;
    logic [CW-1:0]  r_hcount;
    logic           r_drop;
    logic [NW-1:0]  r_count;
    logic [EW-1:0]  r_a, r_b;
    logic [CTW-1:0] r_idx;
    logic [CW-1:0]  r_d;
    logic           r_ok;
    logic [SW-1:0]  r_e;
    logic [CW-1:0]  r_best_d;
    logic [VW-1:0]  r_best_v;
    logic [VW-1:0]  r_cur, r_w, r_h;
    logic           r_first, r_second;

    logic [CTW-1:0] used_n;
    logic           add_bad;
    logic           head_we, link_we, deg_we;
    logic [VW-1:0]  head_wa, head_ra, deg_wa, deg_ra;
    logic [SW-1:0]  link_wa;
    t_head          head_wd;
    t_link          link_wd;
    t_deg           deg_wd;

    always_comb begin
        used_n = (CTW'(r_vcnt) > CTW'(MAX_VERTICES)) ? CTW'(MAX_VERTICES) : CTW'(r_vcnt);
        add_bad = (CTW'(r_a) >= used_n) || (CTW'(r_b) >= used_n) ||
                  ({1'b0, r_hcount} + (CW+1)'(2) > (CW+1)'(HALF_EDGE_SLOTS));
    end

    always_comb begin
        head_we = 1'b0;
        head_wa = r_idx[VW-1:0];
        head_wd = '0;
        head_ra = r_idx[VW-1:0];
        link_we = 1'b0;
        link_wa = r_hcount[SW-1:0];
        link_wd = '{valid: r_head_q.valid, next: r_head_q.slot, far: VW'(r_b)};
        deg_we  = 1'b0;
        deg_wa  = r_idx[VW-1:0];
        deg_wd  = '0;
        deg_ra  = r_idx[VW-1:0];
        case (i_cmd.op)
            OP_WIPE_ALL: begin
                head_we = 1'b1;
                deg_we  = 1'b1;
            end
            OP_WIPE_HEAD: head_we = 1'b1;
            OP_ADD_RD_A:  head_ra = VW'(r_a);
            OP_ADD_WR_A: begin
                head_we = 1'b1;
                head_wa = VW'(r_a);
                head_wd = '{valid: 1'b1, slot: r_hcount[SW-1:0]};
                link_we = 1'b1;
            end
            OP_ADD_RD_B:  head_ra = VW'(r_b);
            OP_ADD_WR_B: begin
                head_we = 1'b1;
                head_wa = VW'(r_b);
                head_wd = '{valid: 1'b1, slot: r_hcount[SW-1:0]};
                link_we = 1'b1;
                link_wd = '{valid: r_head_q.valid, next: r_head_q.slot, far: VW'(r_a)};
            end
            OP_DG_WALK: begin
                deg_we = !r_ok;
                deg_wd = '{marked: 1'b0, deg: r_d};
            end
            OP_TK_HD: begin
                head_ra = r_cur;
                deg_we  = 1'b1;
                deg_wa  = r_cur;
                deg_wd  = '{marked: 1'b1, deg: '0};
            end
            OP_TK_LK:  deg_ra = r_link_q.far;
            OP_TK_DEC: begin
                deg_we = 1'b1;
                deg_wa = r_w;
                deg_wd = '{marked: r_deg_q.marked, deg: r_deg_q.deg - CW'(1)};
            end
            OP_PR_RD:  deg_ra = r_h;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) r_head_mem[head_wa] <= head_wd;
        r_head_q <= r_head_mem[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) r_link_mem[link_wa] <= link_wd;
        r_link_q <= r_link_mem[r_e];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) r_deg_mem[deg_wa] <= deg_wd;
        r_deg_q <= r_deg_mem[deg_ra];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_a <= i_end_a;
                r_b <= i_end_b;
            end
            OP_DG_RD: r_d <= '0;
            OP_DG_HQ: r_e <= r_head_q.slot;
            OP_DG_LK: begin
                r_d <= r_d + CW'(1);
                r_e <= r_link_q.next;
            end
            OP_SC_INIT: begin
                r_best_d <= '0;
                r_best_v <= '0;
            end
            OP_SC_CMP: begin
                if (!r_deg_q.marked && r_deg_q.deg > r_best_d) begin
                    r_best_d <= r_deg_q.deg;
                    r_best_v <= r_idx[VW-1:0];
                end
            end
            OP_SC_END: r_cur <= r_best_v;
            OP_TK_HQ:  r_e <= r_head_q.slot;
            OP_TK_LK: begin
                r_w <= r_link_q.far;
                r_e <= r_link_q.next;
                if (r_first) r_h <= r_link_q.far;
            end
            OP_PR_CHK: if (!r_deg_q.marked) r_cur <= r_h;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt   <= NW'(1);
            r_pair   <= 1'b0;
            r_hcount <= '0;
            r_drop   <= 1'b0;
            r_count  <= '0;
            r_idx    <= '0;
            r_ok     <= 1'b0;
            r_first  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VERTEX_COUNT: r_vcnt <= i_cfg_data;
                    CFG_PAIR_MODE:    r_pair <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_idx   <= '0;
                    r_count <= '0;
                end
                OP_WIPE_ALL: r_idx <= r_idx + CTW'(1);
                OP_WIPE_HEAD: begin
                    r_idx    <= r_idx + CTW'(1);
                    r_hcount <= '0;
                    r_drop   <= 1'b0;
                end
                OP_ADD_RD_A: if (add_bad) r_drop <= 1'b1;
                OP_ADD_WR_A, OP_ADD_WR_B: r_hcount <= r_hcount + CW'(1);
                OP_DG_HQ:   r_ok <= r_head_q.valid;
                OP_DG_WALK: if (!r_ok) r_idx <= r_idx + CTW'(1);
                OP_DG_LK:   r_ok <= r_link_q.valid;
                OP_SC_INIT: r_idx <= '0;
                OP_SC_CMP:  r_idx <= r_idx + CTW'(1);
                OP_SC_END: begin
                    r_first  <= 1'b1;
                    r_second <= 1'b0;
                end
                OP_TK_HD: r_count <= r_count + NW'(1);
                OP_TK_HQ: r_ok <= r_head_q.valid;
                OP_TK_LK: begin
                    r_ok    <= r_link_q.valid;
                    r_first <= 1'b0;
                end
                OP_PR_CHK: if (!r_deg_q.marked) r_second <= 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.add_bad    = add_bad;
        o_sts.idx_end    = (r_idx == used_n);
        o_sts.sweep_last = (r_idx[VW-1:0] == VW'(MAX_VERTICES - 1));
        o_sts.ok         = r_ok;
        o_sts.best_zero  = (r_best_d == '0);
        o_sts.h_marked   = r_deg_q.marked;
        o_sts.second     = r_second;
        o_sts.pair       = r_pair;
    end

    assign o_cover_size    = r_count;
    assign o_edges_dropped = r_drop;

endmodule

FILE: hdl/gvc_ctrl.sv
`timescale 1ns / 1ps
`include "greedy_vertex_cover_defines.svh"

module gvc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_kind,
    input  gvc_pkg::t_sts i_sts,
    output gvc_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import gvc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_RST_CLR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RST_CLR:  if (i_sts.sweep_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        KIND_CLEAR:   n_state = S_CLR;
                        KIND_ADD:     n_state = S_ADD_RD_A;
                        KIND_COMPUTE: n_state = S_DG_RD;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:      if (i_sts.sweep_last) n_state = S_IDLE;
            S_ADD_RD_A: n_state = i_sts.add_bad ? S_IDLE : S_ADD_WR_A;
            S_ADD_WR_A: n_state = S_ADD_RD_B;
            S_ADD_RD_B: n_state = S_ADD_WR_B;
            S_ADD_WR_B: n_state = S_IDLE;
            S_DG_RD:    n_state = i_sts.idx_end ? S_SC_INIT : S_DG_HQ;
            S_DG_HQ:    n_state = S_DG_WALK;
            S_DG_WALK:  n_state = i_sts.ok ? S_DG_LK : S_DG_RD;
            S_DG_LK:    n_state = S_DG_WALK;
            S_SC_INIT:  n_state = S_SC_RD;
            S_SC_RD:    n_state = i_sts.idx_end ? S_SC_END : S_SC_CMP;
            S_SC_CMP:   n_state = S_SC_RD;
            S_SC_END:   n_state = i_sts.best_zero ? S_OUT : S_TK_HD;
            S_TK_HD:    n_state = S_TK_HQ;
            S_TK_HQ:    n_state = S_TK_WALK;
            S_TK_WALK:  n_state = i_sts.ok ? S_TK_LK : S_TK_DONE;
            S_TK_LK:    n_state = S_TK_DEC;
            S_TK_DEC:   n_state = S_TK_WALK;
            S_TK_DONE:  n_state = (i_sts.pair && !i_sts.second) ? S_PR_RD : S_SC_INIT;
            S_PR_RD:    n_state = S_PR_CHK;
            S_PR_CHK:   n_state = i_sts.h_marked ? S_SC_INIT : S_TK_HD;
            S_OUT:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NOP;
        case (r_state)
            S_RST_CLR:  o_cmd.op = OP_WIPE_ALL;
            S_IDLE:     o_cmd.op = i_start ? OP_LOAD : OP_NOP;
            S_CLR:      o_cmd.op = OP_WIPE_HEAD;
            S_ADD_RD_A: o_cmd.op = OP_ADD_RD_A;
            S_ADD_WR_A: o_cmd.op = OP_ADD_WR_A;
            S_ADD_RD_B: o_cmd.op = OP_ADD_RD_B;
            S_ADD_WR_B: o_cmd.op = OP_ADD_WR_B;
            S_DG_RD:    o_cmd.op = OP_DG_RD;
            S_DG_HQ:    o_cmd.op = OP_DG_HQ;
            S_DG_WALK:  o_cmd.op = OP_DG_WALK;
            S_DG_LK:    o_cmd.op = OP_DG_LK;
            S_SC_INIT:  o_cmd.op = OP_SC_INIT;
            S_SC_RD:    o_cmd.op = OP_SC_RD;
            S_SC_CMP:   o_cmd.op = OP_SC_CMP;
            S_SC_END:   o_cmd.op = OP_SC_END;
            S_TK_HD:    o_cmd.op = OP_TK_HD;
            S_TK_HQ:    o_cmd.op = OP_TK_HQ;
            S_TK_LK:    o_cmd.op = OP_TK_LK;
            S_TK_DEC:   o_cmd.op = OP_TK_DEC;
            S_PR_RD:    o_cmd.op = OP_PR_RD;
            S_PR_CHK:   o_cmd.op = OP_PR_CHK;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

    `GVC_ASSERT_NEXT(a_out_one_beat, i_clk, i_rst_n, r_state == S_OUT, r_state == S_IDLE, "result strobe longer than one cycle")
    `GVC_ASSERT_NEXT(a_compute_starts, i_clk, i_rst_n, i_start && !o_busy && i_kind == KIND_COMPUTE, r_state == S_DG_RD, "compute item not started")
    `GVC_ASSERT_NEXT(a_zero_best_ends, i_clk, i_rst_n, r_state == S_SC_END && i_sts.best_zero, o_done, "scan with no candidate did not finish")
    `GVC_ASSERT_NEXT(a_pair_once, i_clk, i_rst_n, r_state == S_TK_DONE && i_sts.second, r_state == S_SC_INIT, "pair partner taken twice")
    `GVC_ASSERT(a_add_bad_no_write, i_clk, i_rst_n, !(r_state == S_ADD_RD_A && i_sts.add_bad) || n_state == S_IDLE, "dropped edge written")

endmodule

FILE: hdl/greedy_vertex_cover.sv
`timescale 1ns / 1ps
// Greedy max-degree vertex cover. One item at a time: busy is high from the accept edge on.
// Add edge: reads, then writes, each endpoint's head; a dropped edge ends at the first read.
// Clear: one head entry a cycle. Compute: rebuilds all degrees from the adjacency lists,
// then each pass takes the unmarked vertex of highest degree (and in pair mode its first listed
// neighbour if unmarked); an empty scan ends it. Strobe lasts one cycle, never stalled.
// Reset (sync, active low) holds busy through a sweep of head and degree tables.
module greedy_vertex_cover (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item channel
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_kind,
    input  logic [gvc_pkg::EW-1:0]     i_end_a,
    input  logic [gvc_pkg::EW-1:0]     i_end_b,
    // result beat
    output logic                       o_done,
    output logic [gvc_pkg::NW-1:0]     o_cover_size,
    output logic                       o_edges_dropped,
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gvc_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [gvc_pkg::NW-1:0]     i_cfg_data
);
    import gvc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Registers take a write in any cycle; software is to write only while idle, the block leaves this to software.
    assign o_cfg_ready = 1'b1;

    // Sequencer: walks lists, scans degrees, picks the cover vertex.
    gvc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Adjacency memories, degree/mark memory, counters.
    gvc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_end_a         (i_end_a),
        .i_end_b         (i_end_b),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_sts           (sts),
        .o_cover_size    (o_cover_size),
        .o_edges_dropped (o_edges_dropped)
    );

endmodule
